### rtl/core/positional_insert_delete_list_top_macros.svh
// assertion macros shared by the list checker
`ifndef POSITIONAL_INSERT_DELETE_LIST_TOP_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_LIST_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define PIDL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define PIDL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/pidl_pkg.sv
// shared types and codes of the positional insert/delete list
`default_nettype none

package pidl_pkg;

  localparam int DATA_W    = 32;
  localparam int POS_W     = 7;
  localparam int INDEX_W   = 6;
  localparam int COUNT_W   = 7;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]               op;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] data_value;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [INDEX_W-1:0]       entry_index;
    logic [1:0]               status;
    logic [COUNT_W-1:0]       list_count;
    logic                     last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic advance;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rsp_last;
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/positional_insert_delete_list_top.sv
// top level of the positional insert/delete list
// insert, delete and OP_NONE: a single word, held in the output register once the captured request has executed
// read-out of n entries: n words, one word per cycle while rsp_stall is low
// each step is set by the controller: capture, shift of the whole cell chain, output register
// one item is in flight at a time; word delivery is paced by one cell read per cycle while rsp_stall is low
// synchronous reset empties the list; stored words are not cleared
`default_nettype none

module positional_insert_delete_list_top #(
  parameter int CAPACITY = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire pidl_pkg::req_t req_word,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output pidl_pkg::rsp_t      rsp_word
);
  import pidl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencing
  pidl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // storage and result formation
  pidl_data #(
    .CAPACITY (CAPACITY)
  ) u_data (
    .clk      (clk),
    .rst      (rst),
    .req_word (req_word),
    .cmd      (cmd),
    .sts      (sts),
    .rsp_word (rsp_word)
  );

endmodule

`default_nettype wire

### rtl/core/pidl_data.sv
// datapath: request register, cell chain, entry count and response register
`default_nettype none

module pidl_data #(
  parameter int CAPACITY = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire pidl_pkg::req_t req_word,
  input  wire pidl_pkg::cmd_t cmd,
  output pidl_pkg::sts_t    sts,
  output pidl_pkg::rsp_t    rsp_word
);
  import pidl_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = IDX_W + 1;

  // captured request
  logic [1:0]               op_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [DATA_W-1:0] val_r;

  // cell chain and count
  logic signed [DATA_W-1:0] cells [CAPACITY];
  logic signed [DATA_W-1:0] cells_next [CAPACITY];
  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic [IDX_W-1:0]         rd_idx;
  logic [IDX_W-1:0]         nidx;

  rsp_t rsp_r;
  rsp_t exec_rsp;
  rsp_t adv_rsp;

  logic [POS_W-1:0] cnt7;
  logic [IDX_W-1:0] pos_idx;
  logic             is_full;
  logic             ins_ok;
  logic             del_ok;

  // decode of the captured operation
  always_comb begin
    cnt7    = POS_W'(count);
    pos_idx = pos_r[IDX_W-1:0];
    is_full = (count == CNT_W'(CAPACITY));
    ins_ok  = (op_r == OP_INSERT) && (pos_r <= cnt7) && !is_full;
    del_ok  = (op_r == OP_DELETE) && (pos_r < cnt7);
  end

  // count after the operation
  always_comb begin
    priority if (ins_ok) begin
      count_next = count + CNT_W'(1);
    end else if (del_ok) begin
      count_next = count - CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  // per-cell shift selection
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cells_next[i] = cells[i];
      if (ins_ok) begin
        if (POS_W'(i) == pos_r) begin
          cells_next[i] = val_r;
        end else if (POS_W'(i) > pos_r) begin
          cells_next[i] = cells[(i > 0) ? i - 1 : 0];
        end
      end else if (del_ok) begin
        if ((POS_W'(i) >= pos_r) && (i < CAPACITY - 1)) begin
          cells_next[i] = cells[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  // first word of an operation
  always_comb begin
    exec_rsp              = '0;
    exec_rsp.list_count   = COUNT_W'(count_next);
    exec_rsp.last         = 1'b1;
    unique case (op_r)
      OP_INSERT: begin
        if (pos_r > cnt7) begin
          exec_rsp.status = ST_RANGE;
        end else if (is_full) begin
          exec_rsp.status = ST_FULL;
        end else begin
          exec_rsp.status = ST_OK;
        end
      end
      OP_DELETE: begin
        if (del_ok) begin
          exec_rsp.status       = ST_OK;
          exec_rsp.result_value = cells[pos_idx];
        end else begin
          exec_rsp.status = ST_RANGE;
        end
      end
      OP_READ: begin
        if (count == '0) begin
          exec_rsp.status = ST_EMPTY;
        end else begin
          exec_rsp.status       = ST_OK;
          exec_rsp.result_value = cells[0];
          exec_rsp.last         = (count == CNT_W'(1));
        end
      end
      OP_NONE: begin
        exec_rsp.status = ST_OK;
      end
    endcase
  end

  // following read-out words
  always_comb begin
    nidx                 = rd_idx + IDX_W'(1);
    adv_rsp              = '0;
    adv_rsp.result_value = cells[nidx];
    adv_rsp.entry_index  = INDEX_W'(nidx);
    adv_rsp.status       = ST_OK;
    adv_rsp.list_count   = COUNT_W'(count);
    adv_rsp.last         = ((CNT_W'(nidx) + CNT_W'(1)) == count);
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= req_word.op;
      pos_r <= req_word.position;
      val_r <= req_word.data_value;
    end
  end

  // cell chain update
  always_ff @(posedge clk) begin
    if (cmd.exec && (ins_ok || del_ok)) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cells[i] <= cells_next[i];
      end
    end
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  // response register and read-out index
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rsp_r  <= exec_rsp;
      rd_idx <= '0;
    end else if (cmd.advance) begin
      rsp_r  <= adv_rsp;
      rd_idx <= nidx;
    end
  end

  assign rsp_word     = rsp_r;
  assign sts.rsp_last = rsp_r.last;

endmodule

`default_nettype wire

### rtl/core/pidl_ctrl.sv
// controller: sequences capture, execution and word delivery
`default_nettype none

module pidl_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  input  wire pidl_pkg::sts_t sts,
  output pidl_pkg::cmd_t      cmd
);
  import pidl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!rsp_stall && sts.rsp_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // handshake and datapath commands
  always_comb begin
    req_stall   = (state != S_IDLE);
    rsp_valid   = (state == S_OUT);
    cmd.load    = (state == S_IDLE) && req_valid;
    cmd.exec    = (state == S_EXEC);
    cmd.advance = (state == S_OUT) && !rsp_stall && !sts.rsp_last;
  end

endmodule

`default_nettype wire

### rtl/core/pidl_checker.sv
// port-level checker for the list, bound to the top level
`default_nettype none

`include "positional_insert_delete_list_top_macros.svh"

module pidl_checker #(
  parameter int CAPACITY = 64
) (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire pidl_pkg::rsp_t rsp_word
);
  import pidl_pkg::*;

  logic               rsp_take;
  logic               req_take;
  logic               rsp_hold;
  logic               rsp_more;
  logic               rsp_err;
  logic               err_ok;
  logic               cap_ok;
  logic               idx_ok;
  logic [INDEX_W-1:0] idx_exp;

  assign rsp_take = rsp_valid && !rsp_stall;
  assign req_take = req_valid && !req_stall;
  assign rsp_hold = rsp_valid && rsp_stall;
  assign rsp_more = rsp_take && !rsp_word.last;
  assign rsp_err  = rsp_valid && (rsp_word.status != ST_OK);
  assign err_ok   = rsp_word.last && (rsp_word.result_value == 0);
  assign cap_ok   = (rsp_word.list_count <= COUNT_W'(CAPACITY));
  assign idx_ok   = (rsp_word.entry_index == idx_exp);

  // index the next read-out word should carry
  always_ff @(posedge clk) begin
    idx_exp <= INDEX_W'(rsp_word.entry_index + 1);
  end

  // a stalled word holds
  `PIDL_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_hold, rsp_valid && $stable(rsp_word), "word not held")

  // count never passes capacity
  `PIDL_ASSERT_NOW(a_count_cap, clk, rst, rsp_valid, cap_ok, "list count above capacity")

  // errors are single, zero-valued words
  `PIDL_ASSERT_NOW(a_err_word, clk, rst, rsp_err, err_ok, "error word malformed")

  // read-out continues with the next index
  `PIDL_ASSERT_NEXT(a_readout_seq, clk, rst, rsp_more, rsp_valid && idx_ok, "read-out index skipped")

  // no new item while a word is pending
  `PIDL_ASSERT_NOW(a_one_item, clk, rst, rsp_valid, !req_take, "item taken while word pending")

endmodule

bind positional_insert_delete_list_top pidl_checker #(
  .CAPACITY (CAPACITY)
) u_pidl_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_word  (rsp_word)
);

`default_nettype wire
